// ===== hdl/array_linked_list_with_free_pool_core_defines.svh =====
// assertion helpers shared by the linked list block
`ifndef ARRAY_LINKED_LIST_WITH_FREE_POOL_CORE_DEFINES_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_POOL_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ALLFP_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ALLFP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/allfp_pkg.sv =====
// ---------------------------------------------------------------------------
// allfp_pkg
// Sizes, operation and status codes and helpers of the linked list block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package allfp_pkg;

    localparam int NODES      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int NODE_W = $clog2(NODES);
    localparam int LINK_W = $clog2(NODES + 1);

    // fixed widths of the port fields
    localparam int OP_W       = 2;
    localparam int TARGET_W   = 4;
    localparam int ITEM_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int NODE_IDX_W = 4;
    localparam int NEXT_W     = 5;
    localparam int HEAD_W     = 5;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SUCC    = 2'd3;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < NIL_LINK;
    endfunction

    function automatic logic target_ok(input logic [TARGET_W-1:0] t);
        return 32'(t) < 32'(NODES);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/allfp_ram.sv =====
// ---------------------------------------------------------------------------
// allfp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module allfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/array_linked_list_with_free_pool_core.sv =====
// ---------------------------------------------------------------------------
// array_linked_list_with_free_pool_core
// Singly linked list kept in a node store, with a chain of free nodes.
// ---------------------------------------------------------------------------
// Use: one command beat on the input channel (operation, has_predecessor,
// target_node, item_data) gives exactly one result beat on the output
// channel. A beat moves when valid is high and stall is low.
// Insert takes the first free node and links it at the head or after
// target_node; delete unlinks the head or the successor of target_node and
// returns the node to the free chain; read returns a node's payload and link.
// Commands are handled one at a time. States from accept to S_DONE, which
// loads the result register: read S_FIRST; refused at accept or unused code
// none; delete after a node with no successor S_FIRST; insert or delete at
// the head S_FIRST, S_WRITE1, S_WRITE2, after a predecessor S_SECOND between
// S_FIRST and S_WRITE1; the next command is taken in S_IDLE. The single read
// and write port of the link memory sets this: each link access is a state.
// A finished result sits in the output register while the next command is
// accepted; if the receiver stalls, a second result waits inside until the
// register frees, and no command is taken in the meantime.
// Reset empties the list and chains all nodes as free, at once: per-node
// valid bits stand in for the initial memory contents, so no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "array_linked_list_with_free_pool_core_defines.svh"

module array_linked_list_with_free_pool_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [allfp_pkg::OP_W-1:0]          operation,
    input  wire logic                                has_predecessor,
    input  wire logic [allfp_pkg::TARGET_W-1:0]      target_node,
    input  wire logic [allfp_pkg::ITEM_W-1:0]        item_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [allfp_pkg::STATUS_W-1:0]      status,
    output logic      [allfp_pkg::NODE_IDX_W-1:0]    node_index,
    output logic      [allfp_pkg::ITEM_W-1:0]        data_out,
    output logic      [allfp_pkg::NEXT_W-1:0]        next_index,
    output logic      [allfp_pkg::HEAD_W-1:0]        head_index,
    output logic                                     pool_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_WRITE1,
        S_WRITE2,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [allfp_pkg::OP_W-1:0]       op_reg;
    logic                             pred_reg;
    logic [allfp_pkg::NODE_W-1:0]     tgt_reg;
    logic [allfp_pkg::DATA_WIDTH-1:0] item_reg;
    logic [allfp_pkg::NODE_W-1:0]     node_reg;
    logic [allfp_pkg::LINK_W-1:0]     link_reg;
    logic [allfp_pkg::LINK_W-1:0]     nf_reg;
    logic [allfp_pkg::DATA_WIDTH-1:0] data_reg;
    logic [allfp_pkg::STATUS_W-1:0]   status_reg;
    logic [allfp_pkg::LINK_W-1:0]     list_head_reg;
    logic [allfp_pkg::LINK_W-1:0]     free_head_reg;

    logic [allfp_pkg::NODES-1:0]      lk_vld_reg;
    logic [allfp_pkg::NODES-1:0]      pay_vld_reg;
    logic                             lk_rvld_reg;
    logic                             pay_rvld_reg;
    logic [allfp_pkg::NODE_W-1:0]     rd_addr_reg;

    logic                             out_valid_reg;
    logic [allfp_pkg::STATUS_W-1:0]   out_status_reg;
    logic [allfp_pkg::NODE_IDX_W-1:0] out_node_reg;
    logic [allfp_pkg::ITEM_W-1:0]     out_data_reg;
    logic [allfp_pkg::NEXT_W-1:0]     out_next_reg;
    logic [allfp_pkg::HEAD_W-1:0]     out_head_reg;
    logic                             out_full_reg;

    logic                             accept;
    logic                             out_free;
    logic                             rd_en;
    logic [allfp_pkg::NODE_W-1:0]     rd_addr;
    logic                             lk_we;
    logic [allfp_pkg::NODE_W-1:0]     lk_waddr;
    logic [allfp_pkg::LINK_W-1:0]     lk_wdata;
    logic                             pay_we;
    logic [allfp_pkg::LINK_W-1:0]     lk_q;
    logic [allfp_pkg::DATA_WIDTH-1:0] pay_q;
    logic [allfp_pkg::LINK_W-1:0]     lk_rd;
    logic [allfp_pkg::DATA_WIDTH-1:0] pay_rd;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // entries never written read as their reset contents
    assign lk_rd  = lk_rvld_reg ? lk_q
                  : allfp_pkg::LINK_W'(rd_addr_reg) + allfp_pkg::LINK_W'(1);
    assign pay_rd = pay_rvld_reg ? pay_q : '1;

    allfp_ram #(
        .WIDTH (allfp_pkg::LINK_W),
        .DEPTH (allfp_pkg::NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (lk_q)
    );

    allfp_ram #(
        .WIDTH (allfp_pkg::DATA_WIDTH),
        .DEPTH (allfp_pkg::NODES)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (node_reg),
        .wdata (item_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (pay_q)
    );

    // memory port control
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        lk_we    = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        pay_we   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en = accept;
                if (operation == allfp_pkg::OP_INSERT)
                begin
                    rd_addr = allfp_pkg::NODE_W'(free_head_reg);
                end
                else if (operation == allfp_pkg::OP_DELETE && !has_predecessor)
                begin
                    rd_addr = allfp_pkg::NODE_W'(list_head_reg);
                end
                else
                begin
                    rd_addr = allfp_pkg::NODE_W'(target_node);
                end
            end
            S_FIRST:
            begin
                if (op_reg == allfp_pkg::OP_INSERT && pred_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = tgt_reg;
                end
                else if (op_reg == allfp_pkg::OP_DELETE && pred_reg
                         && allfp_pkg::link_ok(lk_rd))
                begin
                    // fetch the victim behind the predecessor
                    rd_en   = 1'b1;
                    rd_addr = allfp_pkg::NODE_W'(lk_rd);
                end
            end
            S_SECOND:
            begin
            end
            S_WRITE1:
            begin
                if (pred_reg)
                begin
                    lk_we    = 1'b1;
                    lk_waddr = tgt_reg;
                    lk_wdata = (op_reg == allfp_pkg::OP_INSERT)
                             ? allfp_pkg::LINK_W'(node_reg) : link_reg;
                end
                pay_we = (op_reg == allfp_pkg::OP_INSERT);
            end
            S_WRITE2:
            begin
                lk_we    = 1'b1;
                lk_waddr = node_reg;
                lk_wdata = (op_reg == allfp_pkg::OP_INSERT) ? link_reg : free_head_reg;
            end
            S_DONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            pred_reg       <= 1'b0;
            tgt_reg        <= '0;
            item_reg       <= '0;
            node_reg       <= '0;
            link_reg       <= '0;
            nf_reg         <= '0;
            data_reg       <= '0;
            status_reg     <= allfp_pkg::ST_OK;
            list_head_reg  <= allfp_pkg::NIL_LINK;
            free_head_reg  <= '0;
            lk_vld_reg     <= '0;
            pay_vld_reg    <= '0;
            lk_rvld_reg    <= 1'b0;
            pay_rvld_reg   <= 1'b0;
            rd_addr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= allfp_pkg::ST_OK;
            out_node_reg   <= '0;
            out_data_reg   <= '0;
            out_next_reg   <= '0;
            out_head_reg   <= '0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                lk_rvld_reg  <= lk_vld_reg[rd_addr];
                pay_rvld_reg <= pay_vld_reg[rd_addr];
                rd_addr_reg  <= rd_addr;
            end
            if (lk_we)
            begin
                lk_vld_reg[lk_waddr] <= 1'b1;
            end
            if (pay_we)
            begin
                pay_vld_reg[node_reg] <= 1'b1;
            end

            // the done state loads the register itself
            if (!out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= operation;
                        pred_reg   <= has_predecessor;
                        tgt_reg    <= allfp_pkg::NODE_W'(target_node);
                        item_reg   <= allfp_pkg::DATA_WIDTH'(item_data);
                        node_reg   <= '0;
                        link_reg   <= '0;
                        data_reg   <= '0;
                        status_reg <= allfp_pkg::ST_OK;
                        state_reg  <= S_DONE;
                        unique case (operation)
                            allfp_pkg::OP_INSERT:
                            begin
                                if (!allfp_pkg::link_ok(free_head_reg))
                                begin
                                    status_reg <= allfp_pkg::ST_POOL_FULL;
                                end
                                else if (has_predecessor && !allfp_pkg::target_ok(target_node))
                                begin
                                    status_reg <= allfp_pkg::ST_NO_SUCC;
                                end
                                else
                                begin
                                    node_reg  <= allfp_pkg::NODE_W'(free_head_reg);
                                    state_reg <= S_FIRST;
                                end
                            end
                            allfp_pkg::OP_DELETE:
                            begin
                                if (!allfp_pkg::link_ok(list_head_reg))
                                begin
                                    status_reg <= allfp_pkg::ST_LIST_EMPTY;
                                end
                                else if (has_predecessor && !allfp_pkg::target_ok(target_node))
                                begin
                                    status_reg <= allfp_pkg::ST_NO_SUCC;
                                end
                                else
                                begin
                                    if (!has_predecessor)
                                    begin
                                        node_reg <= allfp_pkg::NODE_W'(list_head_reg);
                                    end
                                    state_reg <= S_FIRST;
                                end
                            end
                            allfp_pkg::OP_READ:
                            begin
                                if (!allfp_pkg::target_ok(target_node))
                                begin
                                    status_reg <= allfp_pkg::ST_NO_SUCC;
                                end
                                else
                                begin
                                    node_reg  <= allfp_pkg::NODE_W'(target_node);
                                    state_reg <= S_FIRST;
                                end
                            end
                            default:
                            begin
                                // unused code: plain ok result, nothing changes
                            end
                        endcase
                    end
                end
                S_FIRST:
                begin
                    unique case (op_reg)
                        allfp_pkg::OP_INSERT:
                        begin
                            nf_reg <= lk_rd;
                            if (pred_reg)
                            begin
                                state_reg <= S_SECOND;
                            end
                            else
                            begin
                                link_reg  <= list_head_reg;
                                state_reg <= S_WRITE1;
                            end
                        end
                        allfp_pkg::OP_DELETE:
                        begin
                            if (!pred_reg)
                            begin
                                link_reg  <= lk_rd;
                                data_reg  <= pay_rd;
                                state_reg <= S_WRITE1;
                            end
                            else if (!allfp_pkg::link_ok(lk_rd))
                            begin
                                status_reg <= allfp_pkg::ST_NO_SUCC;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                node_reg  <= allfp_pkg::NODE_W'(lk_rd);
                                state_reg <= S_SECOND;
                            end
                        end
                        default:
                        begin
                            link_reg  <= lk_rd;
                            data_reg  <= pay_rd;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_SECOND:
                begin
                    link_reg <= lk_rd;
                    if (op_reg == allfp_pkg::OP_DELETE)
                    begin
                        data_reg <= pay_rd;
                    end
                    state_reg <= S_WRITE1;
                end
                S_WRITE1:
                begin
                    if (op_reg == allfp_pkg::OP_DELETE)
                    begin
                        // freed node reads back as the empty marker
                        pay_vld_reg[node_reg] <= 1'b0;
                    end
                    state_reg <= S_WRITE2;
                end
                S_WRITE2:
                begin
                    if (op_reg == allfp_pkg::OP_INSERT)
                    begin
                        free_head_reg <= nf_reg;
                        if (!pred_reg)
                        begin
                            list_head_reg <= allfp_pkg::LINK_W'(node_reg);
                        end
                    end
                    else
                    begin
                        free_head_reg <= allfp_pkg::LINK_W'(node_reg);
                        if (!pred_reg)
                        begin
                            list_head_reg <= link_reg;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_node_reg   <= (status_reg == allfp_pkg::ST_OK)
                                        ? allfp_pkg::NODE_IDX_W'(node_reg) : '0;
                        out_data_reg   <= allfp_pkg::ITEM_W'(data_reg);
                        out_next_reg   <= allfp_pkg::NEXT_W'(link_reg);
                        out_head_reg   <= allfp_pkg::HEAD_W'(list_head_reg);
                        out_full_reg   <= !allfp_pkg::link_ok(free_head_reg);
                        state_reg      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign node_index = out_node_reg;
    assign data_out   = out_data_reg;
    assign next_index = out_next_reg;
    assign head_index = out_head_reg;
    assign pool_full  = out_full_reg;

    `ALLFP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != S_IDLE,
        "accepted beat did not start a command")
    `ALLFP_ASSERT_NOW(a_link_write_state, clk, rst_n, lk_we,
        state_reg == S_WRITE1 || state_reg == S_WRITE2, "link write outside write states")
    `ALLFP_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == S_DONE, "result loaded outside the done state")
    `ALLFP_ASSERT_NOW(a_failed_result_clean, clk, rst_n,
        out_valid && status != allfp_pkg::ST_OK,
        node_index == '0 && next_index == '0 && data_out == '0,
        "failed command carries nonzero result fields")

endmodule

`default_nettype wire
